[rtl/tsg_pkg.sv]
package tsg_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int THR_W   = 32;
  localparam int GRAD_W  = 48;
  localparam int DETO_W  = 64;
  localparam int IDX_W   = 2;

  // Internal arithmetic widths
  localparam int M_W     = COORD_W + 1;       // corner differences
  localparam int PROD_W  = 2 * M_W;           // adjugate partial products
  localparam int ADJ_W   = PROD_W + 1;        // adjugate entries, corners 0..2
  localparam int ADJ3_W  = ADJ_W + 2;         // corner 3 row (negated sum)
  localparam int MAG_W   = ADJ3_W;            // adjugate magnitudes
  localparam int LO_W    = 34;                // low slice of adjugate for det products
  localparam int HI_W    = ADJ_W - LO_W;      // high slice, signed
  localparam int DET_W   = 102;               // exact determinant, 72 fraction bits
  localparam int RND_SHIFT = 24;              // 72 -> 48 fraction bits
  localparam int DQ_W    = DET_W + 1 - RND_SHIFT;
  localparam int QB      = GRAD_W + 1;        // quotient bits kept by the divider
  localparam int RQ_W    = QB + 1;            // quotient after rounding

  localparam int LANES   = 3;
  localparam int CORNERS = 4;

  localparam logic [IDX_W-1:0] CORNER_LAST   = IDX_W'(CORNERS - 1);
  localparam logic [THR_W-1:0] DET_THR_RESET = THR_W'(281);

  // Saturation limits
  localparam logic [GRAD_W-1:0] GRAD_POS_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic [GRAD_W-1:0] GRAD_NEG_MIN = {1'b1, {(GRAD_W-1){1'b0}}};
  localparam logic [RQ_W-1:0]   GRAD_MAG_LIM = RQ_W'(1) << (GRAD_W - 1);
  localparam logic [DETO_W-1:0] DET_POS_MAX  = {1'b0, {(DETO_W-1){1'b1}}};
  localparam logic [DETO_W-1:0] DET_NEG_MIN  = {1'b1, {(DETO_W-1){1'b0}}};
  localparam logic [DQ_W-1:0]   DET_MAG_LIM  = DQ_W'(1) << (DETO_W - 1);

  // Per-corner sideband travelling with the divider lanes
  typedef struct packed {
    logic [DET_W-1:0]  dmag;
    logic [LANES-1:0]  neg;
    logic [LANES-1:0]  ovf;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic              sing;
    logic [DETO_W-1:0] det_bits;
  } tsg_tag_t;

endpackage

[rtl/tsg_ifs.sv]
interface tsg_in_if;
  logic valid;
  logic ready;
  logic signed [tsg_pkg::COORD_W-1:0] x0, y0, z0;
  logic signed [tsg_pkg::COORD_W-1:0] x1, y1, z1;
  logic signed [tsg_pkg::COORD_W-1:0] x2, y2, z2;
  logic signed [tsg_pkg::COORD_W-1:0] x3, y3, z3;

  modport source (output valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3,
                  input ready);
  modport sink (input valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3,
                output ready);
endinterface

interface tsg_out_if;
  logic valid;
  logic ready;
  logic [tsg_pkg::IDX_W-1:0]         corner_index;
  logic signed [tsg_pkg::GRAD_W-1:0] grad_x;
  logic signed [tsg_pkg::GRAD_W-1:0] grad_y;
  logic signed [tsg_pkg::GRAD_W-1:0] grad_z;
  logic signed [tsg_pkg::DETO_W-1:0] jacobian_det;
  logic singular;
  logic last_corner;

  modport source (output valid, corner_index, grad_x, grad_y, grad_z, jacobian_det,
                  singular, last_corner, input ready);
  modport sink (input valid, corner_index, grad_x, grad_y, grad_z, jacobian_det,
                singular, last_corner, output ready);
endinterface

interface tsg_cfg_if;
  logic valid;
  logic ready;
  logic [tsg_pkg::THR_W-1:0] det_threshold;

  modport source (output valid, det_threshold, input ready);
  modport sink (input valid, det_threshold, output ready);
endinterface

[rtl/tsg_div_pipe.sv]
module tsg_div_pipe (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            adv,
  input  logic                                            in_v,
  input  tsg_pkg::tsg_tag_t                               in_tag,
  input  logic [tsg_pkg::LANES-1:0][tsg_pkg::MAG_W-1:0]   in_mag,
  output logic                                            out_v,
  output tsg_pkg::tsg_tag_t                               out_tag,
  output logic [tsg_pkg::LANES-1:0][tsg_pkg::QB-1:0]      out_q,
  output logic [tsg_pkg::LANES-1:0][tsg_pkg::DET_W-1:0]   out_rem
);

  localparam int STEPS = tsg_pkg::QB;
  localparam int LANES = tsg_pkg::LANES;
  localparam int DET_W = tsg_pkg::DET_W;
  localparam int QB    = tsg_pkg::QB;

  logic [STEPS-1:0]                  v_r;
  tsg_pkg::tsg_tag_t                 tag_r   [STEPS];
  logic [LANES-1:0][DET_W-1:0]       rem_r   [STEPS];
  logic [LANES-1:0][QB-1:0]          q_r     [STEPS];

  logic [STEPS-1:0]                  v_in;
  tsg_pkg::tsg_tag_t                 tag_in  [STEPS];
  logic [LANES-1:0][DET_W:0]         t_in    [STEPS];
  logic [LANES-1:0][QB-1:0]          q_in    [STEPS];
  logic [LANES-1:0][DET_W-1:0]       rem_nxt [STEPS];
  logic [LANES-1:0][QB-1:0]          q_nxt   [STEPS];

  // One restoring step per stage: shift the remainder left (the first stage loads the magnitude), subtract if it fits
  always_comb begin
    logic [DET_W:0] diff;
    v_in      = {v_r[STEPS-2:0], in_v};
    tag_in[0] = in_tag;
    for (int l = 0; l < LANES; l++) begin
      t_in[0][l] = {DET_W'(in_mag[l] >> 1), in_mag[l][0]};
      q_in[0][l] = '0;
    end
    for (int j = 1; j < STEPS; j++) begin
      tag_in[j] = tag_r[j-1];
      q_in[j]   = q_r[j-1];
      for (int l = 0; l < LANES; l++) begin
        t_in[j][l] = {rem_r[j-1][l], 1'b0};
      end
    end
    for (int j = 0; j < STEPS; j++) begin
      for (int l = 0; l < LANES; l++) begin
        diff = t_in[j][l] - {1'b0, tag_in[j].dmag};
        if (t_in[j][l] >= {1'b0, tag_in[j].dmag}) begin
          rem_nxt[j][l] = diff[DET_W-1:0];
          q_nxt[j][l]   = {q_in[j][l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[j][l] = t_in[j][l][DET_W-1:0];
          q_nxt[j][l]   = {q_in[j][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r <= tag_in;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign out_v   = v_r[STEPS-1];
  assign out_tag = tag_r[STEPS-1];
  assign out_q   = q_r[STEPS-1];
  assign out_rem = rem_r[STEPS-1];

endmodule

[rtl/tet_shape_gradient.sv]
// Path: corner 0 of a cell passes the front stages, the cell hold register, the divider
//   steps, rounding and output register; corners 1 to 3 follow when out_ch is ready.
// Throughput: one result per cycle while out_ch is ready; a new cell is taken as the
//   per-cell hold register issues the last of its four corners into the divider lanes.
// Reset (rst_n low, synchronous): all valid bits and the corner counter clear,
//   det_threshold returns to 281.
module tet_shape_gradient (
  input  logic       clk,
  input  logic       rst_n,
  tsg_cfg_if.sink    cfg_ch,
  tsg_in_if.sink     in_ch,
  tsg_out_if.source  out_ch
);

  localparam int COORD_W = tsg_pkg::COORD_W;
  localparam int M_W     = tsg_pkg::M_W;
  localparam int PROD_W  = tsg_pkg::PROD_W;
  localparam int ADJ_W   = tsg_pkg::ADJ_W;
  localparam int ADJ3_W  = tsg_pkg::ADJ3_W;
  localparam int MAG_W   = tsg_pkg::MAG_W;
  localparam int LO_W    = tsg_pkg::LO_W;
  localparam int HI_W    = tsg_pkg::HI_W;
  localparam int DET_W   = tsg_pkg::DET_W;
  localparam int DQ_W    = tsg_pkg::DQ_W;
  localparam int QB      = tsg_pkg::QB;
  localparam int RQ_W    = tsg_pkg::RQ_W;
  localparam int GRAD_W  = tsg_pkg::GRAD_W;
  localparam int DETO_W  = tsg_pkg::DETO_W;
  localparam int LANES   = tsg_pkg::LANES;
  localparam int CORNERS = tsg_pkg::CORNERS;
  localparam int IDX_W   = tsg_pkg::IDX_W;
  localparam int FRONT_STAGES = 7;
  localparam logic [DET_W:0] RND_HALF = (DET_W + 1)'(1) << (tsg_pkg::RND_SHIFT - 1);

  // ---------------------------------------------------------------------------
  // Configuration: threshold register, always ready
  // ---------------------------------------------------------------------------
  logic [tsg_pkg::THR_W-1:0] thr_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tsg_pkg::DET_THR_RESET;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.det_threshold;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control
  // adv  : back end (divider, rounding, output register) moves on
  // fen  : front end moves on; only when the cell hold register is free or is
  //        handing over its last corner in this cycle
  // ---------------------------------------------------------------------------
  logic                   out_v_r;
  logic                   cell_v_r;
  logic [IDX_W-1:0]       cnt_r;
  logic                   adv;
  logic                   fen;
  logic [FRONT_STAGES-1:0] fv_r;

  assign adv = !out_v_r || out_ch.ready;
  assign fen = !cell_v_r || (adv && (cnt_r == tsg_pkg::CORNER_LAST));
  assign in_ch.ready = fen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (fen) begin
      fv_r <= {fv_r[FRONT_STAGES-2:0], in_ch.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: Jacobian columns, corner c minus corner 3 along each axis
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] pos [CORNERS][3];
  logic signed [M_W-1:0]     m_r [3][3];

  assign pos[0][0] = in_ch.x0;  assign pos[0][1] = in_ch.y0;  assign pos[0][2] = in_ch.z0;
  assign pos[1][0] = in_ch.x1;  assign pos[1][1] = in_ch.y1;  assign pos[1][2] = in_ch.z1;
  assign pos[2][0] = in_ch.x2;  assign pos[2][1] = in_ch.y2;  assign pos[2][2] = in_ch.z2;
  assign pos[3][0] = in_ch.x3;  assign pos[3][1] = in_ch.y3;  assign pos[3][2] = in_ch.z3;

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m_r[r][c] <= M_W'(pos[c][r]) - M_W'(pos[3][r]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cofactor products. Stage 3: cofactor differences (adjugate)
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] pa_r  [3][3];
  logic signed [PROD_W-1:0] pb_r  [3][3];
  logic signed [M_W-1:0]    m0a_r [3];
  logic signed [M_W-1:0]    m0b_r [3];
  logic signed [ADJ_W-1:0]  adj3s_r [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_adj_k
    for (genvar d = 0; d < 3; d++) begin : g_adj_d
      localparam int D1 = (d + 1) % 3;
      localparam int D2 = (d + 2) % 3;
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      always_ff @(posedge clk) begin
        if (fen) begin
          pa_r[k][d]    <= m_r[D1][K1] * m_r[D2][K2];
          pb_r[k][d]    <= m_r[D1][K2] * m_r[D2][K1];
          adj3s_r[k][d] <= ADJ_W'(pa_r[k][d]) - ADJ_W'(pb_r[k][d]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      m0a_r <= m_r[0];
      m0b_r <= m0a_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: corner 3 row as the negated sum; determinant products split into a
  //          low unsigned slice and a high signed slice of the adjugate
  // ---------------------------------------------------------------------------
  logic signed [ADJ_W-1:0]       adj4_r [3][3];
  logic signed [ADJ3_W-1:0]      adjc_r [3];
  logic signed [LO_W+M_W:0]      plo_r  [3];
  logic signed [HI_W+M_W-1:0]    phi_r  [3];

  always_ff @(posedge clk) begin
    if (fen) begin
      adj4_r <= adj3s_r;
      for (int d = 0; d < 3; d++) begin
        adjc_r[d] <= -(ADJ3_W'(adj3s_r[0][d]) + ADJ3_W'(adj3s_r[1][d])
                       + ADJ3_W'(adj3s_r[2][d]));
      end
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= $signed({1'b0, adj3s_r[k][0][LO_W-1:0]}) * m0b_r[k];
        phi_r[k] <= $signed(adj3s_r[k][0][ADJ_W-1:LO_W]) * m0b_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: recombine products. Stage 6: sum into the determinant
  // ---------------------------------------------------------------------------
  logic signed [DET_W-1:0]  term_r [3];
  logic signed [DET_W-1:0]  det_r;
  logic signed [ADJ3_W-1:0] adj5_r [CORNERS][3];
  logic signed [ADJ3_W-1:0] adj6_r [CORNERS][3];

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int k = 0; k < 3; k++) begin
        term_r[k] <= (DET_W'(phi_r[k]) <<< LO_W) + DET_W'(plo_r[k]);
        for (int d = 0; d < 3; d++) begin
          adj5_r[k][d] <= ADJ3_W'(adj4_r[k][d]);
        end
      end
      adj5_r[3] <= adjc_r;
      det_r     <= term_r[0] + term_r[1] + term_r[2];
      adj6_r    <= adj5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: magnitudes and signs of the determinant and every adjugate entry
  // ---------------------------------------------------------------------------
  logic [DET_W-1:0] dmag_r;
  logic             dneg_r;
  logic             dzero_r;
  logic [MAG_W-1:0] amag_r [CORNERS][3];
  logic             aneg_r [CORNERS][3];

  always_ff @(posedge clk) begin
    if (fen) begin
      dneg_r  <= det_r[DET_W-1];
      dzero_r <= (det_r == '0);
      dmag_r  <= det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
      for (int k = 0; k < CORNERS; k++) begin
        for (int d = 0; d < 3; d++) begin
          aneg_r[k][d] <= adj6_r[k][d][ADJ3_W-1];
          amag_r[k][d] <= adj6_r[k][d][ADJ3_W-1] ? MAG_W'(-adj6_r[k][d])
                                                 : MAG_W'(adj6_r[k][d]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: cell hold register. Round the determinant to 48 fraction bits,
  // saturate it, decide singularity and flag quotients that must saturate
  // (|adj| >= 2|det| means the 49 bit quotient would overflow).
  // ---------------------------------------------------------------------------
  logic [DET_W:0]    dsum;
  logic [DQ_W-1:0]   dq;
  logic [DETO_W-1:0] det_bits_nxt;
  logic              sing_nxt;

  logic [LANES-1:0][MAG_W-1:0] c_amag_r [CORNERS];
  logic [LANES-1:0]            c_gneg_r [CORNERS];
  logic [LANES-1:0]            c_ovf_r  [CORNERS];
  logic [DET_W-1:0]            c_dmag_r;
  logic [DETO_W-1:0]           c_det_r;
  logic                        c_sing_r;

  always_comb begin
    dsum = {1'b0, dmag_r} + RND_HALF;
    dq   = dsum[DET_W:tsg_pkg::RND_SHIFT];
    if (dneg_r) begin
      det_bits_nxt = (dq > tsg_pkg::DET_MAG_LIM) ? tsg_pkg::DET_NEG_MIN
                                                 : -dq[DETO_W-1:0];
    end else begin
      det_bits_nxt = (dq > tsg_pkg::DET_MAG_LIM - 1'b1) ? tsg_pkg::DET_POS_MAX
                                                        : dq[DETO_W-1:0];
    end
    sing_nxt = dzero_r || (dq < DQ_W'(thr_r));
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      c_dmag_r <= dmag_r;
      c_det_r  <= det_bits_nxt;
      c_sing_r <= sing_nxt;
      for (int k = 0; k < CORNERS; k++) begin
        for (int d = 0; d < LANES; d++) begin
          c_amag_r[k][d] <= amag_r[k][d];
          c_gneg_r[k][d] <= aneg_r[k][d] ^ dneg_r;
          c_ovf_r[k][d]  <= (DET_W + 1)'(amag_r[k][d]) >= {dmag_r, 1'b0};
        end
      end
    end
  end

  // Hold the cell for four corner issues; reload as the last corner leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_r <= 1'b0;
      cnt_r    <= '0;
    end else if (fen) begin
      cell_v_r <= fv_r[FRONT_STAGES-1];
      cnt_r    <= '0;
    end else if (adv && cell_v_r) begin
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Corner issue into three divider lanes (x, y, z)
  // ---------------------------------------------------------------------------
  tsg_pkg::tsg_tag_t              iss_tag;
  logic [LANES-1:0][MAG_W-1:0]    iss_mag;

  always_comb begin
    iss_tag.dmag     = c_dmag_r;
    iss_tag.neg      = c_gneg_r[cnt_r];
    iss_tag.ovf      = c_ovf_r[cnt_r];
    iss_tag.idx      = cnt_r;
    iss_tag.last     = (cnt_r == tsg_pkg::CORNER_LAST);
    iss_tag.sing     = c_sing_r;
    iss_tag.det_bits = c_det_r;
    iss_mag          = c_amag_r[cnt_r];
  end

  logic                          div_v;
  tsg_pkg::tsg_tag_t             div_tag;
  logic [LANES-1:0][QB-1:0]      div_q;
  logic [LANES-1:0][DET_W-1:0]   div_rem;

  tsg_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (cell_v_r),
    .in_tag  (iss_tag),
    .in_mag  (iss_mag),
    .out_v   (div_v),
    .out_tag (div_tag),
    .out_q   (div_q),
    .out_rem (div_rem)
  );

  // ---------------------------------------------------------------------------
  // Rounding stage: round to nearest, ties away from zero, on the magnitude
  // ---------------------------------------------------------------------------
  logic                        rnd_v_r;
  tsg_pkg::tsg_tag_t           rnd_tag_r;
  logic [LANES-1:0][RQ_W-1:0]  rq_r;
  logic [LANES-1:0][RQ_W-1:0]  rq_nxt;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rq_nxt[l] = RQ_W'(div_q[l])
                + RQ_W'({div_rem[l], 1'b0} >= {1'b0, div_tag.dmag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
    end else if (adv) begin
      rnd_v_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rnd_tag_r <= div_tag;
      rq_r      <= rq_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: apply sign, saturate, zero singular cells
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][GRAD_W-1:0] grad_nxt;
  logic [LANES-1:0][GRAD_W-1:0] out_grad_r;
  logic [IDX_W-1:0]             out_idx_r;
  logic [DETO_W-1:0]            out_det_r;
  logic                         out_sing_r;
  logic                         out_last_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (rnd_tag_r.sing) begin
        grad_nxt[l] = '0;
      end else if (rnd_tag_r.neg[l]) begin
        grad_nxt[l] = (rnd_tag_r.ovf[l] || (rq_r[l] > tsg_pkg::GRAD_MAG_LIM))
                    ? tsg_pkg::GRAD_NEG_MIN : -rq_r[l][GRAD_W-1:0];
      end else begin
        grad_nxt[l] = (rnd_tag_r.ovf[l] || (rq_r[l] > tsg_pkg::GRAD_MAG_LIM - 1'b1))
                    ? tsg_pkg::GRAD_POS_MAX : rq_r[l][GRAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= rnd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_grad_r <= grad_nxt;
      out_idx_r  <= rnd_tag_r.idx;
      out_det_r  <= rnd_tag_r.det_bits;
      out_sing_r <= rnd_tag_r.sing;
      out_last_r <= rnd_tag_r.last;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.corner_index = out_idx_r;
  assign out_ch.grad_x       = out_grad_r[0];
  assign out_ch.grad_y       = out_grad_r[1];
  assign out_ch.grad_z       = out_grad_r[2];
  assign out_ch.jacobian_det = out_det_r;
  assign out_ch.singular     = out_sing_r;
  assign out_ch.last_corner  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cell_v_r |-> (cnt_r == '0))
    else $error("corner counter nonzero with no cell held");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_v_r && adv && (cnt_r != tsg_pkg::CORNER_LAST))
      |=> (cell_v_r && (cnt_r == $past(cnt_r) + 1'b1)))
    else $error("cell dropped or corner skipped before last corner issued");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_last_r == (out_idx_r == tsg_pkg::CORNER_LAST)))
    else $error("last_corner disagrees with corner_index");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_sing_r) |-> (out_grad_r == '0))
    else $error("singular cell gave nonzero gradient");

endmodule
